>>> sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property on i_clk, switched off while i_rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// A condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_CLK(lbl, !(cond), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/mhfa_pkg.sv
// Shared constants and codes for the memory hole fit allocator.
`default_nettype none
package mhfa_pkg;

    // Default table geometry.
    localparam int HOLE_SLOTS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Stream field widths.
    localparam int ACTION_W  = 1;
    localparam int SLOT_F_W  = 4;
    localparam int AMOUNT_W  = 16;
    localparam int GRANT_W   = 1;
    localparam int TDATA_W   = 24;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;

    // Fit policy codes.
    localparam int POLICY_W = 2;
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // Hole count register.
    localparam int COUNT_REG_W = 5;
    localparam logic [COUNT_REG_W-1:0] HOLE_COUNT_RST = 5'd16;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

endpackage
`default_nettype wire

>>> sv/memory_hole_fit_allocator_core.sv
// Memory hole fit allocator: top level with scan sequencer and output register.
//
// Input stream (s_axis): one transaction per item. tuser carries the action
// (load a hole size or allocate), tdata carries the hole slot and the amount.
// Output stream (m_axis): one transaction per item. tuser carries the grant
// flag, tdata carries the chosen hole and the size left in it.
// Configuration: i_cfg_wr_en writes fit_policy (index 0) or hole_count
// (index 1) at the clock edge; write only while the block is idle.
// A load goes from acceptance to the write-back state and then into the output
// register. An allocate reads the hole memory one entry per cycle and compares
// the returned entries one at a time; the scan covers N entries, where N is
// hole_count limited to HOLE_SLOTS, through the registered memory read port.
// One item is in work at a time; the next one is accepted once
// its result sits in the output register.
// Reset clears the hole table (all sizes read as zero), sets fit_policy to
// first fit and hole_count to 16, and empties the output register.
// While the receiver stalls, a result waits in the output register; the
// next item may be accepted and worked on, and it then holds until the
// output register frees.
`default_nettype none
module memory_hole_fit_allocator_core #(
    parameter int HOLE_SLOTS = mhfa_pkg::HOLE_SLOTS_DEF,
    parameter int SIZE_BITS  = mhfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [mhfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mhfa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [mhfa_pkg::TDATA_W-1:0]      s_axis_tdata,  // [3:0] hole_slot, [19:4] amount
    input  wire logic [mhfa_pkg::ACTION_W-1:0]     s_axis_tuser,  // [0] action
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [mhfa_pkg::TDATA_W-1:0]      m_axis_tdata,  // [3:0] chosen_hole, [19:4] left_over
    output logic      [mhfa_pkg::GRANT_W-1:0]      m_axis_tuser   // [0] granted
);

    `include "assert_macros.svh"

    localparam int SLOT_W = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(HOLE_SLOTS + 1);
    localparam int CMP_W  = (SIZE_BITS > mhfa_pkg::AMOUNT_W) ? SIZE_BITS : mhfa_pkg::AMOUNT_W;
    localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);
    localparam int PAD_W  = mhfa_pkg::TDATA_W - mhfa_pkg::SLOT_F_W - mhfa_pkg::AMOUNT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    // Control state.
    t_state                              r_state;
    logic [mhfa_pkg::POLICY_W-1:0]       r_policy;
    logic [mhfa_pkg::COUNT_REG_W-1:0]    r_hole_count;
    logic                                r_out_valid;
    logic [CNT_W-1:0]                    r_rd_idx;
    logic                                r_cmp_vld;
    logic                                r_have;

    // Item and scan payload.
    logic                                r_is_alloc;
    logic [mhfa_pkg::SLOT_F_W-1:0]       r_slot;
    logic [mhfa_pkg::AMOUNT_W-1:0]       r_amount;
    logic [CNT_W-1:0]                    r_count;
    logic [SLOT_W-1:0]                   r_cmp_idx;
    logic [SLOT_W-1:0]                   r_pick;
    logic [SIZE_BITS-1:0]                r_pick_size;
    logic                                r_out_granted;
    logic [mhfa_pkg::SLOT_F_W-1:0]       r_out_hole;
    logic [mhfa_pkg::AMOUNT_W-1:0]       r_out_left;

    logic                                s_accept;
    logic [CNT_W-1:0]                    count_in;
    logic                                rd_en;
    logic [SIZE_BITS-1:0]                rd_data;
    logic [CMP_W-1:0]                    amt_w;
    logic [CMP_W-1:0]                    rd_w;
    logic [CMP_W-1:0]                    pick_w;
    logic [CMP_W-1:0]                    load_w;
    logic                                rd_fits;
    logic                                take;
    logic                                slot_ok;
    logic                                grant;
    logic                                fin_go;
    logic                                mem_wr;
    logic [SLOT_W-1:0]                   wr_addr;
    logic [SIZE_BITS-1:0]                wr_data;

    // Hole table.
    mhfa_hole_mem #(
        .DEPTH (HOLE_SLOTS),
        .WIDTH (SIZE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[SLOT_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= mhfa_pkg::POLICY_FIRST;
            r_hole_count <= mhfa_pkg::HOLE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                mhfa_pkg::CFG_FIT_POLICY: begin
                    r_policy <= i_cfg_wdata[mhfa_pkg::POLICY_W-1:0];
                end
                mhfa_pkg::CFG_HOLE_COUNT: begin
                    r_hole_count <= i_cfg_wdata[mhfa_pkg::COUNT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Entries in use, limited to the table depth.
    assign count_in = (32'(r_hole_count) > 32'(HOLE_SLOTS)) ? CNT_W'(HOLE_SLOTS)
                                                            : CNT_W'(r_hole_count);

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Scan read issue: one entry per cycle until the count is reached.
    assign rd_en = (r_state == S_SCAN) && (r_rd_idx < r_count);

    // Compare the entry returned by the memory against the request and the pick.
    assign amt_w   = CMP_W'(r_amount);
    assign rd_w    = CMP_W'(rd_data);
    assign pick_w  = CMP_W'(r_pick_size);
    assign rd_fits = (rd_w >= amt_w);

    always_comb begin
        unique case (r_policy)
            mhfa_pkg::POLICY_FIRST: take = rd_fits && !r_have;
            mhfa_pkg::POLICY_BEST:  take = rd_fits && (!r_have || rd_w < pick_w);
            mhfa_pkg::POLICY_WORST: take = !r_have || rd_w > pick_w;
            default:                take = 1'b0;
        endcase
    end

    // Final decision and write-back.
    assign slot_ok = (32'(r_slot) < 32'(HOLE_SLOTS));
    assign load_w  = (amt_w > SIZE_MAX) ? SIZE_MAX : amt_w;
    assign grant   = r_is_alloc ? (r_have && ((r_policy != mhfa_pkg::POLICY_WORST)
                                              || (pick_w >= amt_w)))
                                : slot_ok;
    assign fin_go  = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);
    assign mem_wr  = fin_go && grant;
    assign wr_addr = r_is_alloc ? r_pick : SLOT_W'(r_slot);
    assign wr_data = r_is_alloc ? SIZE_BITS'(pick_w - amt_w) : SIZE_BITS'(load_w);

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !fin_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_is_alloc <= (s_axis_tuser == mhfa_pkg::ACT_ALLOC);
                        r_slot     <= s_axis_tdata[mhfa_pkg::SLOT_F_W-1:0];
                        r_amount   <= s_axis_tdata[mhfa_pkg::SLOT_F_W +: mhfa_pkg::AMOUNT_W];
                        r_count    <= count_in;
                        r_rd_idx   <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_have     <= 1'b0;
                        r_state    <= (s_axis_tuser == mhfa_pkg::ACT_ALLOC) ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= rd_en;
                    r_cmp_idx <= r_rd_idx[SLOT_W-1:0];
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (r_cmp_vld && take) begin
                        r_have      <= 1'b1;
                        r_pick      <= r_cmp_idx;
                        r_pick_size <= rd_data;
                    end
                    if (!rd_en && !r_cmp_vld) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= grant;
                        r_out_hole    <= grant ? (r_is_alloc ? mhfa_pkg::SLOT_F_W'(r_pick)
                                                             : r_slot)
                                               : '0;
                        r_out_left    <= grant ? mhfa_pkg::AMOUNT_W'(wr_data) : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_granted;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_left, r_out_hole};

    // The scan index never runs past the entries in use.
    `ASSERT_CLK(a_scan_bound, (r_state == S_SCAN) |-> (r_rd_idx <= r_count),
                "scan index overran the hole count")
    // A granted allocate always names an entry inside the scanned range.
    `ASSERT_NEVER(a_pick_range,
                  fin_go && r_is_alloc && grant && (CNT_W'(r_pick) >= r_count),
                  "granted hole lies outside the entries in use")
    // An accepted load goes straight to the write-back step.
    `ASSERT_CLK(a_load_path, (s_accept && (s_axis_tuser == mhfa_pkg::ACT_LOAD))
                |=> (r_state == S_FIN), "load did not go to write-back")
    // The memory is written only when a result is delivered to the output register.
    `ASSERT_CLK(a_wr_result, mem_wr |=> (r_out_valid && r_out_granted),
                "table written without a granted result")

endmodule
`default_nettype wire

>>> sv/mhfa_hole_mem.sv
// Hole size memory with registered read and per-entry written flags.
`default_nettype none
module mhfa_hole_mem #(
    parameter int DEPTH = mhfa_pkg::HOLE_SLOTS_DEF,
    parameter int WIDTH = mhfa_pkg::SIZE_BITS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    // Written flags: an entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Storage array with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

>>> tb/memory_hole_fit_allocator_monitor.sv
// Stream monitor that predicts hole allocator results and checks every output transaction.
module memory_hole_fit_allocator_monitor #(
    parameter int HOLE_SLOTS = mhfa_pkg::HOLE_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mhfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mhfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [mhfa_pkg::TDATA_W-1:0]    i_in_data,   // [3:0] hole_slot, [19:4] amount
    input  logic [mhfa_pkg::ACTION_W-1:0]   i_in_user,   // [0] action
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [mhfa_pkg::TDATA_W-1:0]    i_out_data,  // [3:0] chosen_hole, [19:4] left_over
    input  logic [mhfa_pkg::GRANT_W-1:0]    i_out_user,  // [0] granted
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          granted;
        logic [mhfa_pkg::SLOT_F_W-1:0] chosen_hole;
        logic [mhfa_pkg::AMOUNT_W-1:0] left_over;
    } t_alloc_result;

    // Shadow copy of the hole table and the configuration registers.
    logic [mhfa_pkg::AMOUNT_W-1:0]    hole_sizes [HOLE_SLOTS];
    logic [mhfa_pkg::POLICY_W-1:0]    fit_policy;
    logic [mhfa_pkg::COUNT_REG_W-1:0] hole_count;

    t_alloc_result awaited_results [$];
    int fail_count = 0;
    int pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Apply one load or allocate to the shadow table and return its answer.
    task automatic predict_allocation(input logic [mhfa_pkg::ACTION_W-1:0] action,
                                      input logic [mhfa_pkg::SLOT_F_W-1:0] slot,
                                      input logic [mhfa_pkg::AMOUNT_W-1:0] amount,
                                      output t_alloc_result result);
        int  in_use;
        int  pick;
        bit  found;
        result = '0;
        found  = 1'b0;
        pick   = 0;
        in_use = (hole_count > HOLE_SLOTS) ? HOLE_SLOTS : int'(hole_count);
        if (action == mhfa_pkg::ACT_LOAD) begin
            hole_sizes[slot]   = amount;
            result.granted     = 1'b1;
            result.chosen_hole = slot;
            result.left_over   = amount;
        end else begin
            case (fit_policy)
                mhfa_pkg::POLICY_FIRST: begin
                    for (int i = 0; i < in_use; i++) begin
                        if (!found && hole_sizes[i] >= amount) begin
                            found = 1'b1;
                            pick  = i;
                        end
                    end
                end
                mhfa_pkg::POLICY_BEST: begin
                    // Smallest hole that fits; a strict compare keeps the lower index on ties.
                    for (int i = 0; i < in_use; i++) begin
                        if (hole_sizes[i] >= amount &&
                            (!found || hole_sizes[i] < hole_sizes[pick])) begin
                            found = 1'b1;
                            pick  = i;
                        end
                    end
                end
                mhfa_pkg::POLICY_WORST: begin
                    // Largest hole first, then grant only if the amount fits in it.
                    if (in_use > 0) begin
                        for (int i = 1; i < in_use; i++) begin
                            if (hole_sizes[i] > hole_sizes[pick]) begin
                                pick = i;
                            end
                        end
                        found = (hole_sizes[pick] >= amount);
                    end
                end
                default: begin
                    // The unused policy code never grants.
                end
            endcase
            if (found) begin
                hole_sizes[pick]   = hole_sizes[pick] - amount;
                result.granted     = 1'b1;
                result.chosen_hole = mhfa_pkg::SLOT_F_W'(pick);
                result.left_over   = hole_sizes[pick];
            end
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track configuration, predict on each input transaction, check each output transaction.
    always @(posedge i_clk) begin : watch
        t_alloc_result predicted;
        t_alloc_result oldest;
        if (!i_rst_n) begin
            foreach (hole_sizes[i]) hole_sizes[i] = '0;
            fit_policy = mhfa_pkg::POLICY_FIRST;
            hole_count = mhfa_pkg::HOLE_COUNT_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == mhfa_pkg::CFG_FIT_POLICY) begin
                    fit_policy = i_cfg_wdata[mhfa_pkg::POLICY_W-1:0];
                end else if (i_cfg_idx == mhfa_pkg::CFG_HOLE_COUNT) begin
                    hole_count = i_cfg_wdata[mhfa_pkg::COUNT_REG_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_allocation(i_in_user, i_in_data[mhfa_pkg::SLOT_F_W-1:0],
                                   i_in_data[mhfa_pkg::SLOT_F_W +: mhfa_pkg::AMOUNT_W],
                                   predicted);
                awaited_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("Output transaction with no result awaited: tdata %h tuser %h",
                           i_out_data, i_out_user);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    compare_field("granted", oldest.granted, i_out_user[0]);
                    compare_field("chosen_hole", oldest.chosen_hole,
                                  i_out_data[mhfa_pkg::SLOT_F_W-1:0]);
                    compare_field("left_over", oldest.left_over,
                                  i_out_data[mhfa_pkg::SLOT_F_W +: mhfa_pkg::AMOUNT_W]);
                end
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

>>> tb/memory_hole_fit_allocator_core_test.sv
// Top-level testbench for the hole allocator: clock, reset, stimulus and verdict.
module memory_hole_fit_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 5;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEMS_PER_SET = 40;
    localparam int SETS_PER_RUN  = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [mhfa_pkg::POLICY_W-1:0] POLICY_UNUSED = 2'd3;
    localparam logic [mhfa_pkg::AMOUNT_W-1:0] AMOUNT_FULL   = 16'hFFFF;
    localparam logic [mhfa_pkg::AMOUNT_W-1:0] AMOUNT_TOP    = 16'h8000;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [mhfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [mhfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mhfa_pkg::TDATA_W-1:0]    s_axis_tdata  = '0;  // [3:0] hole_slot, [19:4] amount
    logic [mhfa_pkg::ACTION_W-1:0]   s_axis_tuser  = '0;  // [0] action
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mhfa_pkg::TDATA_W-1:0]    m_axis_tdata;        // [3:0] chosen_hole, [19:4] left_over
    logic [mhfa_pkg::GRANT_W-1:0]    m_axis_tuser;        // [0] granted

    int fail_count;
    int pending_count;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_held      = 1'b0;

    memory_hole_fit_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    memory_hole_fit_allocator_monitor alloc_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a solid hold-off while rx_held is set.
    always @(negedge i_clk) begin
        m_axis_tready <= !rx_held && ($urandom_range(99) >= rx_stall_pct);
    end

    // Hold the receiver off for a fixed number of cycles.
    task automatic hold_receiver(input int cycles);
        rx_held = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_held = 1'b0;
    endtask

    // Offer one transaction, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_item(input logic [mhfa_pkg::ACTION_W-1:0] action,
                             input logic [mhfa_pkg::SLOT_F_W-1:0] slot,
                             input logic [mhfa_pkg::AMOUNT_W-1:0] amount);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= mhfa_pkg::TDATA_W'({amount, slot});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Random item: small sizes dominate so that fits, exact fits and ties happen often.
    task automatic send_random_item();
        logic [mhfa_pkg::ACTION_W-1:0] action;
        logic [mhfa_pkg::AMOUNT_W-1:0] amount;
        int                            pick;
        action = ($urandom_range(99) < 40) ? mhfa_pkg::ACT_LOAD : mhfa_pkg::ACT_ALLOC;
        pick   = $urandom_range(9);
        if (pick <= 5) begin
            amount = mhfa_pkg::AMOUNT_W'($urandom_range(40));
        end else if (pick <= 7) begin
            amount = mhfa_pkg::AMOUNT_W'($urandom_range(1000));
        end else if (pick == 8) begin
            amount = mhfa_pkg::AMOUNT_W'($urandom_range(65535));
        end else begin
            case ($urandom_range(2))
                0:       amount = '0;
                1:       amount = AMOUNT_TOP;
                default: amount = AMOUNT_FULL;
            endcase
        end
        send_item(action, mhfa_pkg::SLOT_F_W'($urandom_range(15)), amount);
    endtask

    // Drop valid and wait until every awaited result has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mhfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mhfa_pkg::CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [mhfa_pkg::POLICY_W-1:0] policy,
                             input logic [mhfa_pkg::COUNT_REG_W-1:0] count);
        settle();
        write_reg(mhfa_pkg::CFG_FIT_POLICY, mhfa_pkg::CFG_DATA_W'(policy));
        write_reg(mhfa_pkg::CFG_HOLE_COUNT, mhfa_pkg::CFG_DATA_W'(count));
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        logic [mhfa_pkg::POLICY_W-1:0]    policies [3];
        logic [mhfa_pkg::COUNT_REG_W-1:0] count;
        policies = '{mhfa_pkg::POLICY_FIRST, mhfa_pkg::POLICY_BEST, mhfa_pkg::POLICY_WORST};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table under reset settings (first fit, all 16 entries).
        send_item(mhfa_pkg::ACT_ALLOC, 4'hA, '0);     // zero request fits an empty hole
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd1);    // nothing fits
        send_item(mhfa_pkg::ACT_LOAD, 4'd0, AMOUNT_FULL);
        send_item(mhfa_pkg::ACT_LOAD, 4'd15, AMOUNT_FULL);
        send_item(mhfa_pkg::ACT_LOAD, 4'd5, 16'd10);
        send_item(mhfa_pkg::ACT_LOAD, 4'd7, 16'd10);
        send_item(mhfa_pkg::ACT_LOAD, 4'd9, 16'd20);
        send_item(mhfa_pkg::ACT_ALLOC, 4'd3, AMOUNT_FULL);  // full-size grant empties hole 0
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd12);

        // Best fit with a tie between two equal holes.
        configure(mhfa_pkg::POLICY_BEST, 5'd16);
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd10);
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd3);

        // Worst fit: a grant from the largest hole, then a miss.
        configure(mhfa_pkg::POLICY_WORST, 5'd16);
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd1);
        send_item(mhfa_pkg::ACT_ALLOC, '0, AMOUNT_FULL);

        // The unused policy code never grants.
        configure(POLICY_UNUSED, 5'd16);
        send_item(mhfa_pkg::ACT_ALLOC, '0, '0);

        // No entries in use; loads still land anywhere in the table.
        configure(mhfa_pkg::POLICY_FIRST, 5'd0);
        send_item(mhfa_pkg::ACT_ALLOC, '0, '0);
        send_item(mhfa_pkg::ACT_LOAD, 4'd3, 16'd7);

        // Hole count above the table size.
        configure(mhfa_pkg::POLICY_BEST, 5'd31);
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd5);

        // Single entry in use, and a load beyond the hole count.
        configure(mhfa_pkg::POLICY_WORST, 5'd1);
        send_item(mhfa_pkg::ACT_ALLOC, '0, '0);
        send_item(mhfa_pkg::ACT_LOAD, 4'd12, 16'h5A5A);
        send_item(mhfa_pkg::ACT_ALLOC, '0, 16'd1);

        // Random part over four idling phases, each with several settings.
        for (int phase = 0; phase < 4; phase++) begin
            for (int set = 0; set < SETS_PER_RUN; set++) begin
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(2))
                        0:       count = 5'd1;
                        1:       count = 5'd16;
                        default: count = 5'd31;
                    endcase
                end else begin
                    count = mhfa_pkg::COUNT_REG_W'($urandom_range(2, 16));
                end
                configure(policies[(set + phase) % 3], count);
                case (phase)
                    0: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 0;
                    end
                    1: begin
                        tx_idle_pct  = 81;
                        rx_stall_pct = 0;
                    end
                    2: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 81;
                    end
                    default: begin
                        tx_idle_pct  = 19;
                        rx_stall_pct = 19;
                    end
                endcase
                if (phase == 0 && set == 0) begin
                    // Long receiver hold-off while the sender keeps offering.
                    fork
                        hold_receiver(HOLD_CYCLES);
                        repeat (ITEMS_PER_SET) send_random_item();
                    join
                end else begin
                    repeat (ITEMS_PER_SET) send_random_item();
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> memory_hole_fit_allocator_core.f
+incdir+sv
sv/mhfa_pkg.sv
sv/mhfa_hole_mem.sv
sv/memory_hole_fit_allocator_core.sv
tb/memory_hole_fit_allocator_monitor.sv
tb/memory_hole_fit_allocator_core_test.sv
